[rtl/core/eba_pkg.sv]
// Shared types and constants for the eight-bit ALU with decimal-mode flags.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package eba_pkg;

  typedef enum logic [3:0] {
    MODE_ADC  = 4'd0,
    MODE_SBC  = 4'd1,
    MODE_AND  = 4'd2,
    MODE_ORA  = 4'd3,
    MODE_EOR  = 4'd4,
    MODE_ASL  = 4'd5,
    MODE_LSR  = 4'd6,
    MODE_ROL  = 4'd7,
    MODE_ROR  = 4'd8,
    MODE_INC  = 4'd9,
    MODE_DEC  = 4'd10,
    MODE_LOAD = 4'd11,
    MODE_CMP  = 4'd12,
    MODE_BIT  = 4'd13
  } mode_e;

  localparam logic       BCD_ENABLE_RESET = 1'b1;
  localparam logic [3:0] BCD_LO_LIMIT     = 4'h9;
  localparam logic [5:0] BCD_HI_LIMIT     = 6'h09;
  localparam logic [9:0] BCD_LO_ADJ       = 10'h006;
  localparam logic [9:0] BCD_HI_ADJ       = 10'h060;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] reg_operand;
    logic [7:0] mem_operand;
    logic       carry_in;
    logic       overflow_in;
    logic       decimal_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       write_result;
    logic       carry_out;
    logic       overflow_out;
    logic       negative_out;
    logic       zero_out;
  } out_word_t;

  typedef struct packed {
    logic bcd_enable;
  } cfg_word_t;

endpackage

`default_nettype wire

[rtl/core/eba_if.sv]
// Valid/ready channel interfaces for the operation, result and configuration words.
// Depends on eba_pkg for the payload types.
`default_nettype none

interface eba_in_if;
  logic               valid;
  logic               ready;
  eba_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eba_out_if;
  logic               valid;
  logic               ready;
  eba_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eba_cfg_if;
  logic               valid;
  logic               ready;
  eba_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/eba_cfg.sv]
// Configuration register holding the decimal-adjust enable.
// Depends on eba_pkg and the eba_cfg_if interface.
`default_nettype none

module eba_cfg (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  eba_cfg_if.sink       cfg_i,
  output logic          bcd_enable_o
);

  logic bcd_enable_q;
  logic bcd_enable_d;

  assign cfg_i.ready  = 1'b1;
  assign bcd_enable_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.data.bcd_enable : bcd_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_enable_q <= eba_pkg::BCD_ENABLE_RESET;
    end else begin
      bcd_enable_q <= bcd_enable_d;
    end
  end

  assign bcd_enable_o = bcd_enable_q;

endmodule

`default_nettype wire

[rtl/core/eba_alu.sv]
// Combinational ALU datapath: add/subtract with decimal adjust, logic, shifts and flags.
// Depends on eba_pkg for the word types, mode codes and adjust constants.
`default_nettype none

module eba_alu (
  input  wire eba_pkg::in_word_t op_i,
  input  wire logic              bcd_enable_i,
  output eba_pkg::out_word_t     res_o
);

  logic [7:0] addend;
  logic [9:0] sum;
  logic [9:0] sum_lo;
  logic [9:0] sum_adj;
  logic [8:0] diff;
  logic       add_v;
  logic       dec_mode;
  logic [7:0] res;
  logic       wr;
  logic       c;
  logic       v;
  logic       n;
  logic       z;
  logic       nz_from_res;

  assign dec_mode = op_i.decimal_in & bcd_enable_i;
  assign addend   = (op_i.mode == eba_pkg::MODE_SBC) ? ~op_i.mem_operand : op_i.mem_operand;
  assign sum      = {2'b00, op_i.reg_operand} + {2'b00, addend} + {9'd0, op_i.carry_in};
  assign add_v    = ~(op_i.reg_operand[7] ^ addend[7]) & (op_i.reg_operand[7] ^ sum[7]);
  assign sum_lo   = (dec_mode && (sum[3:0] > eba_pkg::BCD_LO_LIMIT)) ?
                    sum + eba_pkg::BCD_LO_ADJ : sum;
  assign sum_adj  = (dec_mode && (sum_lo[9:4] > eba_pkg::BCD_HI_LIMIT)) ?
                    sum_lo + eba_pkg::BCD_HI_ADJ : sum_lo;
  assign diff     = {1'b0, op_i.reg_operand} - {1'b0, op_i.mem_operand};

  always_comb begin
    res         = op_i.reg_operand;
    wr          = 1'b1;
    c           = op_i.carry_in;
    v           = op_i.overflow_in;
    n           = 1'b0;
    z           = 1'b0;
    nz_from_res = 1'b1;
    unique case (eba_pkg::mode_e'(op_i.mode))
      eba_pkg::MODE_ADC, eba_pkg::MODE_SBC: begin
        res = sum_adj[7:0];
        c   = sum_adj[8];
        v   = add_v;
      end
      eba_pkg::MODE_AND: res = op_i.reg_operand & op_i.mem_operand;
      eba_pkg::MODE_ORA: res = op_i.reg_operand | op_i.mem_operand;
      eba_pkg::MODE_EOR: res = op_i.reg_operand ^ op_i.mem_operand;
      eba_pkg::MODE_ASL: begin
        res = {op_i.mem_operand[6:0], 1'b0};
        c   = op_i.mem_operand[7];
      end
      eba_pkg::MODE_LSR: begin
        res = {1'b0, op_i.mem_operand[7:1]};
        c   = op_i.mem_operand[0];
      end
      eba_pkg::MODE_ROL: begin
        res = {op_i.mem_operand[6:0], op_i.carry_in};
        c   = op_i.mem_operand[7];
      end
      eba_pkg::MODE_ROR: begin
        res = {op_i.carry_in, op_i.mem_operand[7:1]};
        c   = op_i.mem_operand[0];
      end
      eba_pkg::MODE_INC: res = op_i.mem_operand + 8'd1;
      eba_pkg::MODE_DEC: res = op_i.mem_operand - 8'd1;
      eba_pkg::MODE_LOAD: res = op_i.mem_operand;
      eba_pkg::MODE_CMP: begin
        wr          = 1'b0;
        c           = ~diff[8];
        nz_from_res = 1'b0;
        n           = diff[7];
        z           = (op_i.reg_operand == op_i.mem_operand);
      end
      eba_pkg::MODE_BIT: begin
        wr          = 1'b0;
        nz_from_res = 1'b0;
        n           = op_i.mem_operand[7];
        v           = op_i.mem_operand[6];
        z           = ((op_i.reg_operand & op_i.mem_operand) == 8'd0);
      end
      default: wr = 1'b0;
    endcase
    if (nz_from_res) begin
      n = res[7];
      z = (res == 8'd0);
    end
  end

  assign res_o.result_byte  = res;
  assign res_o.write_result = wr;
  assign res_o.carry_out    = c;
  assign res_o.overflow_out = v;
  assign res_o.negative_out = n;
  assign res_o.zero_out     = z;

endmodule

`default_nettype wire

[rtl/core/eight_bit_alu_with_bcd_flags.sv]
// Top level: input register, ALU datapath and result register with valid/ready flow control.
// Depends on eba_pkg, the eba_*_if interfaces, eba_cfg and eba_alu.
//
//   Channel  Direction  Word
//   in_i     sink       mode, reg_operand, mem_operand, carry_in, overflow_in, decimal_in
//   out_o    source     result_byte, write_result, carry/overflow/negative/zero flags
//   cfg_i    sink       bcd_enable
//
// A word passes through the input register and then the result register.
// With the result side taking every cycle, a new word is accepted on every clock.
// Each stage holds while the stage after it is full and stalled; ready propagates back.
// Reset empties both stages and sets bcd_enable; the configuration port is always ready.
`default_nettype none

module eight_bit_alu_with_bcd_flags (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  eba_in_if.sink    in_i,
  eba_out_if.source out_o,
  eba_cfg_if.sink   cfg_i
);

  logic               bcd_enable;
  logic               s1_valid_q;
  logic               s1_valid_d;
  eba_pkg::in_word_t  s1_data_q;
  logic               s1_ready;
  logic               s2_valid_q;
  logic               s2_valid_d;
  eba_pkg::out_word_t s2_data_q;
  logic               s2_ready;
  eba_pkg::out_word_t alu_res;
  logic               in_fire;
  logic               s2_load;

  eba_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .bcd_enable_o (bcd_enable)
  );

  eba_alu u_alu (
    .op_i         (s1_data_q),
    .bcd_enable_i (bcd_enable),
    .res_o        (alu_res)
  );

  assign s2_ready   = !s2_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign in_fire    = in_i.valid && s1_ready;
  assign s2_load    = s1_valid_q && s2_ready;
  assign s1_valid_d = in_fire ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);
  assign s2_valid_d = s2_load ? 1'b1 : (out_o.ready ? 1'b0 : s2_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_i.data;
    end
    if (s2_load) begin
      s2_data_q <= alu_res;
    end
  end

  assign out_o.valid = s2_valid_q;
  assign out_o.data  = s2_data_q;

  a_in_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted word did not reach the input register");

  a_s1_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> s2_valid_q)
    else $error("word in the input register was dropped");

  a_s2_gets_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> (s2_data_q == $past(alu_res)))
    else $error("result register does not hold the ALU result");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_data_q)))
    else $error("input register changed while the result side was stalled");

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for eight_bit_alu_with_bcd_flags: directed and random ALU words under handshake stalls.
// Depends on eba_pkg and the eba_*_if interfaces; results are checked against a built-in predictor.
`timescale 1ns / 1ps

module tb;

  localparam logic [3:0] MODE_SPARE_LO = 4'd14;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_WORDS = 440;

  class alu_flag_scoreboard;
    logic bcd_enable;
    eba_pkg::out_word_t expected_results[$];
    int unsigned errors;

    function new();
      bcd_enable = eba_pkg::BCD_ENABLE_RESET;
      errors = 0;
    endfunction

    function void set_bcd_enable(logic value);
      bcd_enable = value;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function eba_pkg::out_word_t alu_result(eba_pkg::in_word_t w);
      eba_pkg::out_word_t r;
      logic [7:0] opnd;
      logic [7:0] diff;
      logic [9:0] sum;
      bit own_nz;
      own_nz = 1'b0;
      r.result_byte = w.reg_operand;
      r.write_result = 1'b1;
      r.carry_out = w.carry_in;
      r.overflow_out = w.overflow_in;
      r.negative_out = 1'b0;
      r.zero_out = 1'b0;
      case (w.mode)
        eba_pkg::MODE_ADC, eba_pkg::MODE_SBC: begin
          opnd = (w.mode == eba_pkg::MODE_SBC) ? ~w.mem_operand : w.mem_operand;
          sum = 10'(w.reg_operand) + 10'(opnd) + 10'(w.carry_in);
          r.overflow_out = ~(w.reg_operand[7] ^ opnd[7]) & (w.reg_operand[7] ^ sum[7]);
          if (w.decimal_in && bcd_enable) begin
            if (sum[3:0] > 4'd9) sum = sum + 10'h006;
            if (sum[9:4] > 6'h09) sum = sum + 10'h060;
          end
          r.carry_out = sum[8];
          r.result_byte = sum[7:0];
        end
        eba_pkg::MODE_AND: r.result_byte = w.reg_operand & w.mem_operand;
        eba_pkg::MODE_ORA: r.result_byte = w.reg_operand | w.mem_operand;
        eba_pkg::MODE_EOR: r.result_byte = w.reg_operand ^ w.mem_operand;
        eba_pkg::MODE_ASL: begin
          r.carry_out = w.mem_operand[7];
          r.result_byte = {w.mem_operand[6:0], 1'b0};
        end
        eba_pkg::MODE_LSR: begin
          r.carry_out = w.mem_operand[0];
          r.result_byte = {1'b0, w.mem_operand[7:1]};
        end
        eba_pkg::MODE_ROL: begin
          r.carry_out = w.mem_operand[7];
          r.result_byte = {w.mem_operand[6:0], w.carry_in};
        end
        eba_pkg::MODE_ROR: begin
          r.carry_out = w.mem_operand[0];
          r.result_byte = {w.carry_in, w.mem_operand[7:1]};
        end
        eba_pkg::MODE_INC: r.result_byte = w.mem_operand + 8'd1;
        eba_pkg::MODE_DEC: r.result_byte = w.mem_operand - 8'd1;
        eba_pkg::MODE_LOAD: r.result_byte = w.mem_operand;
        eba_pkg::MODE_CMP: begin
          own_nz = 1'b1;
          r.write_result = 1'b0;
          r.carry_out = (w.reg_operand >= w.mem_operand);
          diff = w.reg_operand - w.mem_operand;
          r.negative_out = diff[7];
          r.zero_out = (w.reg_operand == w.mem_operand);
        end
        eba_pkg::MODE_BIT: begin
          own_nz = 1'b1;
          r.write_result = 1'b0;
          r.negative_out = w.mem_operand[7];
          r.overflow_out = w.mem_operand[6];
          r.zero_out = ((w.reg_operand & w.mem_operand) == 8'h00);
        end
        default: begin
          r.write_result = 1'b0;
        end
      endcase
      if (!own_nz) begin
        r.negative_out = r.result_byte[7];
        r.zero_out = (r.result_byte == 8'h00);
      end
      return r;
    endfunction

    function void take_op(eba_pkg::in_word_t w);
      expected_results.push_back(alu_result(w));
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s expected %0h actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(eba_pkg::out_word_t got);
      eba_pkg::out_word_t want;
      if (expected_results.size() == 0) begin
        $error("result word arrived with no expectation waiting");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("result_byte", want.result_byte, got.result_byte);
      compare("write_result", 8'(want.write_result), 8'(got.write_result));
      compare("carry_out", 8'(want.carry_out), 8'(got.carry_out));
      compare("overflow_out", 8'(want.overflow_out), 8'(got.overflow_out));
      compare("negative_out", 8'(want.negative_out), 8'(got.negative_out));
      compare("zero_out", 8'(want.zero_out), 8'(got.zero_out));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int unsigned cycles = 0;
  alu_flag_scoreboard sb = new();

  eba_in_if in_ch();
  eba_out_if out_ch();
  eba_cfg_if cfg_ch();

  eight_bit_alu_with_bcd_flags DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) sb.take_op(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // The result side stalls in random bursts while sink_stalls is set.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic eba_pkg::in_word_t make_op(logic [3:0] mode, logic [7:0] a, logic [7:0] m,
                                                logic c, logic v, logic d);
    eba_pkg::in_word_t w;
    w.mode = mode;
    w.reg_operand = a;
    w.mem_operand = m;
    w.carry_in = c;
    w.overflow_in = v;
    w.decimal_in = d;
    return w;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] corners[4];
    corners = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    case ($urandom_range(0, 7))
      0: return corners[$urandom_range(0, 3)];
      1, 2: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic eba_pkg::in_word_t rand_op();
    logic [3:0] mode;
    mode = ($urandom_range(0, 9) < 4) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
    return make_op(mode, rand_byte(), rand_byte(), 1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  task automatic issue_op(input eba_pkg::in_word_t w);
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic hold_input(input int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_bcd_enable(input logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_bcd_enable(value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned count, input bit mid_drain);
    for (int unsigned i = 0; i < count; i++) begin
      if (mid_drain && i == count / 2) wait_results_drained();
      issue_op(rand_op());
      if (src_gaps && $urandom_range(0, 9) == 0) hold_input($urandom_range(1, 8));
    end
  endtask

  initial begin
    eba_pkg::in_word_t directed[$];
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corners of every operation, with decimal adjust enabled from reset.
    directed.push_back(make_op(eba_pkg::MODE_ADC, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_ADC, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_ADC, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_ADC, 8'h09, 8'h01, 1'b0, 1'b0, 1'b1));
    directed.push_back(make_op(eba_pkg::MODE_ADC, 8'h99, 8'h01, 1'b0, 1'b0, 1'b1));
    directed.push_back(make_op(eba_pkg::MODE_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    directed.push_back(make_op(eba_pkg::MODE_SBC, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_SBC, 8'h10, 8'h01, 1'b1, 1'b0, 1'b1));
    directed.push_back(make_op(eba_pkg::MODE_AND, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1));
    directed.push_back(make_op(eba_pkg::MODE_ORA, 8'h00, 8'h80, 1'b0, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_EOR, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_ASL, 8'h00, 8'h80, 1'b0, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_LSR, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_ROR, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_INC, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_DEC, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_LOAD, 8'h00, 8'h80, 1'b0, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_CMP, 8'h10, 8'h20, 1'b1, 1'b0, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_CMP, 8'h40, 8'h40, 1'b0, 1'b1, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_BIT, 8'hC0, 8'h3F, 1'b1, 1'b1, 1'b0));
    directed.push_back(make_op(eba_pkg::MODE_BIT, 8'h3F, 8'hC0, 1'b0, 1'b0, 1'b0));
    directed.push_back(make_op(MODE_SPARE_LO, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1));
    directed.push_back(make_op(MODE_SPARE_HI, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0));
    foreach (directed[i]) begin
      issue_op(directed[i]);
      if ($urandom_range(0, 3) == 0) hold_input($urandom_range(1, 8));
    end

    wait_results_drained();
    write_bcd_enable(1'b0);
    run_random(PHASE_WORDS, 1'b1);
    wait_results_drained();
    write_bcd_enable(1'b1);
    run_random(PHASE_WORDS, 1'b0);
    wait_results_drained();
    write_bcd_enable(1'b0);
    run_random(PHASE_WORDS, 1'b0);
    wait_results_drained();
    write_bcd_enable(1'b1);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_random(PHASE_WORDS, 1'b0);

    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
